[hdl/isms_pkg.sv]
// Shared types and codes for the integer set with running maximum.
package isms_pkg;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL        = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] max_value;
		logic               nonempty;
		logic [6:0]         count;
	} res_t;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_REMOVE,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [31:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEARCH,
		B_SHIFT,
		B_SCAN,
		B_DONE
	} back_state_t;

endpackage

[hdl/isms_front.sv]
// Front end: accepts requests, decodes the operation and queues commands for the engine.
module isms_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  isms_pkg::req_t req,
	output logic           cmd_valid,
	output isms_pkg::cmd_t cmd,
	input  logic           cmd_take
);

	isms_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     n_q;
	logic           wr_ok;
	logic           rd_ok;
	isms_pkg::cmd_t cmd_new;

	always_comb begin
		cmd_new.value = req.value;
		unique case (req.operation)
			isms_pkg::OP_ADD:    cmd_new.kind = isms_pkg::CMD_ADD;
			isms_pkg::OP_REMOVE: cmd_new.kind = isms_pkg::CMD_REMOVE;
			isms_pkg::OP_CLEAR:  cmd_new.kind = isms_pkg::CMD_CLEAR;
			default:             cmd_new.kind = isms_pkg::CMD_NOP;
		endcase
	end

	assign full      = (n_q == 2'd2);
	assign cmd_valid = (n_q != 2'd0);
	assign cmd       = ent_q[rp_q];
	assign wr_ok     = push && !full;
	assign rd_ok     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			ent_q[wp_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (wr_ok) begin
				wp_q <= !wp_q;
			end
			if (rd_ok) begin
				rp_q <= !rp_q;
			end
			if (wr_ok && !rd_ok) begin
				n_q <= n_q + 2'd1;
			end else if (rd_ok && !wr_ok) begin
				n_q <= n_q - 2'd1;
			end
		end
	end

endmodule

[hdl/isms_back.sv]
// Engine: entry memory, search / shift / rescan sequencer and the result register.
module isms_back #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  isms_pkg::cmd_t cmd,
	output logic           cmd_take,
	output logic           empty,
	input  logic           pop,
	output isms_pkg::res_t res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [31:0] mem [CAPACITY];
	logic [31:0] rd_data_q;

	isms_pkg::back_state_t state_q, state_d;
	isms_pkg::cmd_t        cmd_q;
	logic [CW-1:0]         idx_q, idx_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic signed [31:0]    max_q, max_d;
	logic [1:0]            st_q, st_d;
	logic                  first_q, first_d;
	logic                  pend_q;
	logic [IW-1:0]         pend_idx_q;
	logic                  res_vld_q;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          we;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          load_res;
	logic          hit;

	assign rd_addr = idx_q[IW-1:0];
	assign hit     = pend_q && (rd_data_q == cmd_q.value);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		max_d    = max_q;
		st_d     = st_q;
		first_d  = first_q;
		rd_en    = 1'b0;
		we       = 1'b0;
		wr_addr  = cnt_q[IW-1:0];
		wr_data  = cmd_q.value;
		cmd_take = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			isms_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					idx_d    = '0;
					st_d     = isms_pkg::ST_OK;
					case (cmd.kind)
						isms_pkg::CMD_ADD, isms_pkg::CMD_REMOVE: state_d = isms_pkg::B_SEARCH;
						isms_pkg::CMD_CLEAR: begin
							cnt_d   = '0;
							max_d   = '0;
							state_d = isms_pkg::B_DONE;
						end
						default: state_d = isms_pkg::B_DONE;
					endcase
				end
			end
			isms_pkg::B_SEARCH: begin
				if (hit) begin
					if (cmd_q.kind == isms_pkg::CMD_REMOVE) begin
						idx_d   = CW'(pend_idx_q) + CW'(1);
						state_d = isms_pkg::B_SHIFT;
					end else begin
						// duplicate add
						state_d = isms_pkg::B_DONE;
					end
				end else if (idx_q == cnt_q) begin
					state_d = isms_pkg::B_DONE;
					if (cmd_q.kind == isms_pkg::CMD_REMOVE) begin
						st_d = isms_pkg::ST_NOT_PRESENT;
					end else if (cnt_q == CW'(CAPACITY)) begin
						st_d = isms_pkg::ST_FULL;
					end else begin
						we    = 1'b1;
						cnt_d = cnt_q + CW'(1);
						if (cnt_q == '0 || cmd_q.value > max_q) begin
							max_d = cmd_q.value;
						end
					end
				end else begin
					rd_en = 1'b1;
					idx_d = idx_q + CW'(1);
				end
			end
			isms_pkg::B_SHIFT: begin
				if (idx_q < cnt_q) begin
					rd_en = 1'b1;
					idx_d = idx_q + CW'(1);
				end
				if (pend_q) begin
					// entry read last cycle moves down one slot
					we      = 1'b1;
					wr_addr = pend_idx_q - IW'(1);
					wr_data = rd_data_q;
				end
				if (idx_q == cnt_q && !pend_q) begin
					cnt_d   = cnt_q - CW'(1);
					idx_d   = '0;
					first_d = 1'b1;
					if (cmd_q.value == max_q && cnt_q != CW'(1)) begin
						state_d = isms_pkg::B_SCAN;
					end else begin
						state_d = isms_pkg::B_DONE;
					end
				end
			end
			isms_pkg::B_SCAN: begin
				if (idx_q < cnt_q) begin
					rd_en = 1'b1;
					idx_d = idx_q + CW'(1);
				end
				if (pend_q && (first_q || $signed(rd_data_q) > max_q)) begin
					max_d   = $signed(rd_data_q);
					first_d = 1'b0;
				end
				if (idx_q == cnt_q && !pend_q) begin
					state_d = isms_pkg::B_DONE;
				end
			end
			isms_pkg::B_DONE: begin
				if (!res_vld_q || pop) begin
					load_res = 1'b1;
					state_d  = isms_pkg::B_IDLE;
				end
			end
			default: state_d = isms_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isms_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			max_q     <= '0;
			pend_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			max_q  <= max_d;
			pend_q <= rd_en;
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		st_q       <= st_d;
		first_q    <= first_d;
		pend_idx_q <= rd_addr;
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (load_res) begin
			res.status    <= st_q;
			res.max_value <= (cnt_q != '0) ? max_q : 32'sd0;
			res.nonempty  <= (cnt_q != '0);
			res.count     <= 7'(cnt_q);
		end
	end

	assign empty = !res_vld_q;

endmodule

[hdl/integer_set_with_max_core.sv]
// Clear or unused code goes straight to the result; add or remove first searches the entry memory;
// remove of a present value then shifts later entries down, and rescans for the maximum if it was removed.
// The entry memory is read one entry per cycle on each pass.
// One request is in the engine at a time; two more queue in front of it.
// Async reset clears count, maximum and queues; the entry memory is not cleared.
module integer_set_with_max_core #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  isms_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output isms_pkg::res_t res
);

	logic           cmd_valid;
	logic           cmd_take;
	isms_pkg::cmd_t cmd;

	isms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	isms_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

[tb/sv/integer_set_with_max_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the integer set with running maximum.
module integer_set_with_max_core_tb;

	localparam int CAPACITY = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 1400;
	localparam int FILL_POOL = 80;
	localparam int LONG_HOLD = 1200;
	localparam int STALL_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 300;

	// Tracks the set contents and queues the result each accepted request must produce.
	class set_max_board;
		logic signed [31:0] held[CAPACITY];
		int unsigned n_held;
		logic signed [31:0] top;
		isms_pkg::res_t pending_results[$];
		int unsigned errors;

		function new();
			n_held = 0;
			top = '0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function isms_pkg::res_t apply_request(input isms_pkg::req_t r);
			isms_pkg::res_t want;
			logic signed [31:0] v;
			bit found;
			int unsigned pos;
			v = r.value;
			found = 0;
			pos = 0;
			want.status = isms_pkg::ST_OK;
			for (int unsigned i = 0; i < n_held; i++) begin
				if (!found && held[i] == v) begin
					found = 1;
					pos = i;
				end
			end
			case (r.operation)
				isms_pkg::OP_ADD: begin
					if (!found) begin
						if (n_held >= CAPACITY) begin
							want.status = isms_pkg::ST_FULL;
						end else begin
							held[n_held] = v;
							if (n_held == 0 || v > top)
								top = v;
							n_held++;
						end
					end
				end
				isms_pkg::OP_REMOVE: begin
					if (found) begin
						for (int unsigned i = pos; i + 1 < n_held; i++)
							held[i] = held[i + 1];
						n_held--;
						// removing the maximum forces a rescan of what is left
						if (v == top && n_held != 0) begin
							top = held[0];
							for (int unsigned i = 1; i < n_held; i++)
								if (held[i] > top)
									top = held[i];
						end
					end else begin
						want.status = isms_pkg::ST_NOT_PRESENT;
					end
				end
				isms_pkg::OP_CLEAR: begin
					n_held = 0;
					top = '0;
				end
				default: ;
			endcase
			want.max_value = (n_held != 0) ? top : 32'sd0;
			want.nonempty = (n_held != 0);
			want.count = 7'(n_held);
			return want;
		endfunction

		function void note_request(input isms_pkg::req_t r);
			isms_pkg::res_t want;
			want = apply_request(r);
			pending_results = {pending_results, want};
		endfunction

		task report_mismatch(input string msg);
			errors++;
			$display("MISMATCH at %0t ns: %s", $time, msg);
		endtask

		task check_result(input isms_pkg::res_t got);
			isms_pkg::res_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no request outstanding", got));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.max_value !== want.max_value)
					report_mismatch($sformatf("max_value %0d, want %0d",
						got.max_value, want.max_value));
				if (got.nonempty !== want.nonempty)
					report_mismatch($sformatf("nonempty %b, want %b",
						got.nonempty, want.nonempty));
				if (got.count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d",
						got.count, want.count));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	isms_pkg::req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	isms_pkg::res_t res;

	set_max_board board = new();
	int unsigned items_sent = 0;
	bit send_rush = 0;
	bit mid_pause_done = 0;
	int unsigned stuck_cycles = 0;

	integer_set_with_max_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// extremes and tiny values show up often so max rescans and ties get exercised
	function automatic logic signed [31:0] random_value();
		int pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0: return INT_MIN;
			1: return INT_MAX;
			2: return $signed($urandom_range(0, 16)) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [1:0] op, input logic signed [31:0] val);
		isms_pkg::req_t r;
		int gap;
		r.operation = op;
		r.value = val;
		if ($urandom_range(0, 39) == 0)
			send_rush = !send_rush;
		gap = send_rush ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_request(r);
		items_sent++;
	endtask

	task automatic wait_for_drain();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// walk a pool of fresh values into the set until it overflows
	task automatic fill_to_capacity();
		logic signed [31:0] pool[FILL_POOL];
		int pick;
		for (int i = 0; i < FILL_POOL; i++)
			pool[i] = ($urandom_range(0, 15) == 0) ? random_value() : $signed($urandom);
		for (int i = 0; i < FILL_POOL; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5 && i > 0)
				send_request(isms_pkg::OP_REMOVE, pool[$urandom_range(0, i - 1)]);
			else if (pick < 12 && i > 0)
				send_request(isms_pkg::OP_ADD, pool[$urandom_range(0, i - 1)]);
			send_request(isms_pkg::OP_ADD, pool[i]);
		end
		repeat ($urandom_range(1, 4)) send_request(isms_pkg::OP_ADD, $urandom);
		repeat ($urandom_range(1, 4))
			send_request(isms_pkg::OP_ADD, pool[$urandom_range(0, FILL_POOL - 1)]);
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, FILL_POOL - 1);
			send_request(isms_pkg::OP_REMOVE, pool[pick]);
			send_request(isms_pkg::OP_ADD,
				($urandom_range(0, 1) == 0) ? pool[pick] : $signed($urandom));
		end
		if ($urandom_range(0, 9) < 7)
			send_request(isms_pkg::OP_CLEAR, $urandom);
	endtask

	// small value pool so removes mostly hit
	task automatic churn_small_set();
		logic signed [31:0] pool[12];
		int size, len, pick;
		size = $urandom_range(1, 12);
		len = $urandom_range(20, 60);
		for (int i = 0; i < size; i++)
			pool[i] = random_value();
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_request(isms_pkg::OP_ADD, pool[$urandom_range(0, size - 1)]);
			else if (pick < 94)
				send_request(isms_pkg::OP_REMOVE, pool[$urandom_range(0, size - 1)]);
			else if (pick < 97)
				send_request(isms_pkg::OP_CLEAR, $urandom);
			else
				send_request(OP_UNUSED, $urandom);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(10, 30))
			send_request(2'($urandom_range(0, 3)), $urandom);
	endtask

	initial begin : stimulus
		int kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(isms_pkg::OP_REMOVE, 32'sd5);      // remove on empty set
		send_request(isms_pkg::OP_ADD, INT_MIN);
		send_request(isms_pkg::OP_ADD, INT_MAX);
		send_request(isms_pkg::OP_ADD, 32'sd0);
		send_request(isms_pkg::OP_ADD, -32'sd1);
		send_request(isms_pkg::OP_ADD, INT_MAX);        // duplicate
		send_request(isms_pkg::OP_REMOVE, 32'sd12345);  // absent
		send_request(isms_pkg::OP_REMOVE, INT_MAX);     // max removed, rescan
		send_request(isms_pkg::OP_REMOVE, INT_MIN);     // head removed, shift down
		send_request(OP_UNUSED, 32'shAAAA_5555);
		send_request(isms_pkg::OP_ADD, 32'sh5555_5555);
		send_request(isms_pkg::OP_REMOVE, -32'sd1);
		send_request(isms_pkg::OP_REMOVE, 32'sh5555_5555);
		send_request(isms_pkg::OP_REMOVE, 32'sd0);      // last value gone, stale max hidden
		send_request(isms_pkg::OP_ADD, -32'sd7);        // first add after empty, below stale max
		send_request(isms_pkg::OP_CLEAR, 32'shFFFF_FFFF);
		send_request(isms_pkg::OP_ADD, 32'sd100);
		send_request(isms_pkg::OP_ADD, 32'sd100);
		send_request(isms_pkg::OP_REMOVE, 32'sd100);
		send_request(isms_pkg::OP_CLEAR, 32'sd0);       // clear on empty set
		send_request(OP_UNUSED, 32'shFFFF_FFFF);
		wait_for_drain();

		while (items_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 2)
				fill_to_capacity();
			else if (kind < 7)
				churn_small_set();
			else if (kind < 9)
				send_noise();
			else
				send_request(isms_pkg::OP_CLEAR, $urandom);
			if (!mid_pause_done && items_sent >= RANDOM_ITEMS / 2) begin
				mid_pause_done = 1;
				wait_for_drain();
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : result_sink
		int gap;
		bit rush;
		int unsigned results_seen;
		rush = 0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rush = !rush;
			gap = rush ? 0 : $urandom_range(0, 16);
			// long hold-off lets the block back up and stall its input
			if (results_seen == 300 || results_seen == 1000)
				gap = LONG_HOLD;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			board.check_result(res);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
